// ===== hdl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WAV stream sample decoder package
// Shared widths, result and sample-format codes, tag words and small helpers.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int HEADER_BYTES = 44;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 144;
	localparam int OUT_USER_W = 2;

	typedef enum logic [1:0] {
		RK_HDR_OK      = 2'd0,
		RK_HDR_BAD     = 2'd1,
		RK_UNSUPPORTED = 2'd2,
		RK_SAMPLE      = 2'd3
	} result_kind_t;

	typedef enum logic [2:0] {
		SM_U8  = 3'd0,
		SM_S16 = 3'd1,
		SM_S24 = 3'd2,
		SM_S32 = 3'd3,
		SM_F32 = 3'd4
	} sample_mode_t;

	localparam logic [15:0] FMT_PCM   = 16'd1;
	localparam logic [15:0] FMT_FLOAT = 16'd3;

	// tag words as they sit in the stream, first byte lowest
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// ceil(2^33 / 3): floor(x / 3) == (x * RECIP3) >> 33 for any 32-bit x
	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

	// flag a header byte that sits inside a tag and differs from it
	function automatic logic tag_mismatch(input logic [5:0] pos, input logic [7:0] b);
		logic [31:0] word;
		logic        check;
		word  = '0;
		check = 1'b1;
		unique case (pos[5:2])
			4'd0:    word = TAG_RIFF;
			4'd2:    word = TAG_WAVE;
			4'd3:    word = TAG_FMT;
			4'd9:    word = TAG_DATA;
			default: check = 1'b0;
		endcase
		return check && (b != word[{pos[1:0], 3'b000} +: 8]);
	endfunction

	function automatic logic [2:0] bytes_per_sample(input sample_mode_t mode);
		logic [2:0] n;
		unique case (mode)
			SM_U8:   n = 3'd1;
			SM_S16:  n = 3'd2;
			SM_S24:  n = 3'd3;
			default: n = 3'd4;
		endcase
		return n;
	endfunction

endpackage

// ===== hdl/wav_stream_sample_decoder.sv =====
// ----------------------------------------------------------------------------
// WAV stream sample decoder
// Parses a 44-byte RIFF/WAVE PCM header from a byte stream and turns the
// following little-endian samples into saturated Q1.31 values.
// ----------------------------------------------------------------------------
// Feed the file one byte per beat, with tuser set on its first byte. A byte is
// taken in every cycle in which the capture register is free or drains, so the
// block keeps up with one byte per clock; the byte that completes a result beat
// puts it in the capture register, and it then moves to the output register. The
// rate is set by the capture stage: header tags, field bytes, the byte count
// and sample assembly are all handled at the edge that takes the byte, and the
// conversion to Q1.31 (shift-and-add scaling, float alignment) and the sample
// total (one 32x32 multiply for three-byte samples) fill the following stage.
// At the 44th header byte one status beat is given: header bad if any of the
// RIFF, WAVE, fmt or data tags differs, unsupported unless integer PCM at 8,
// 16, 24 or 32 bits or float at 32 bits, else ok with the header fields. After
// an ok header with a non-zero sample total, samples follow; the one that
// reaches the total carries tlast and the block then ignores bytes until the
// next start of file. A start-of-file byte restarts header capture at any time.
// ----------------------------------------------------------------------------
module wav_stream_sample_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	// input bytes
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [wsd_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]                        s_axis_tuser,  // [0] start_of_file
	// results
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [31:0] sample_value, [47:32] audio_format, [63:48] bits_per_sample,
	// [79:64] channel_count, [111:80] sample_rate, [143:112] sample_total
	output logic [wsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic [wsd_pkg::OUT_USER_W-1:0]    m_axis_tuser,  // [1:0] result_kind
	output logic                              m_axis_tlast   // last_sample
);

	import wsd_pkg::*;

	// phase codes
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_SAMPLES = 2'd2;

	// header byte positions
	localparam logic [5:0] POS_LAST = 6'(HEADER_BYTES - 1);
	localparam logic [5:0] OFS_FMT  = 6'd20;
	localparam logic [5:0] OFS_CH   = 6'd22;
	localparam logic [5:0] OFS_RATE = 6'd24;
	localparam logic [5:0] OFS_BITS = 6'd34;
	localparam logic [5:0] OFS_SIZE = 6'd40;

	typedef struct packed {
		result_kind_t kind;
		sample_mode_t mode;
		logic         last;
		logic [31:0]  raw;   // assembled sample, or data chunk size on status
		logic [15:0]  fmt;
		logic [15:0]  bits;
		logic [15:0]  ch;
		logic [31:0]  rate;
	} capture_t;

	// ------------------------------------------------------------------
	// Handshake
	// ------------------------------------------------------------------
	logic     cap_valid_s1;
	capture_t cap_s1;
	logic     out_load;
	logic     in_acc;

	assign out_load      = cap_valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !cap_valid_s1 || out_load;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// ------------------------------------------------------------------
	// Capture stage: parse header, assemble samples
	// ------------------------------------------------------------------
	logic [1:0]   phase_q;
	logic [5:0]   hpos_q;
	logic         tag_bad_q;
	logic [1:0]   bis_q;
	logic [23:0]  partial_q;
	logic [31:0]  rem_q;        // data bytes still owed to whole samples
	sample_mode_t mode_q;
	logic [15:0]  fmt_q;
	logic [15:0]  bits_q;
	logic [15:0]  ch_q;
	logic [31:0]  rate_q;
	logic [23:0]  size_lo_q;

	logic [7:0]   din;
	logic         sof;
	logic [1:0]   phase_eff;
	logic [5:0]   hpos_eff;
	logic         tag_bad_d;
	logic         supported;
	sample_mode_t mode_d;
	logic [2:0]   hdr_bps;
	logic [31:0]  size_d;
	logic [2:0]   cur_bps;
	logic         smp_done;
	logic [31:0]  raw_d;
	logic [31:0]  rem_next;
	logic         smp_last;
	logic         cap_load;

	assign din = s_axis_tdata;
	assign sof = s_axis_tuser[0];

	// a start-of-file byte is header byte 0 whatever the phase
	assign phase_eff = sof ? PH_HEADER : phase_q;
	assign hpos_eff  = sof ? 6'd0 : hpos_q;

	assign tag_bad_d = ((hpos_eff != 6'd0) && tag_bad_q) || tag_mismatch(hpos_eff, din);

	always_comb begin
		supported = 1'b1;
		mode_d    = SM_S32;
		if (fmt_q == FMT_FLOAT && bits_q == 16'd32) begin
			mode_d = SM_F32;
		end else if (fmt_q == FMT_PCM && bits_q == 16'd8) begin
			mode_d = SM_U8;
		end else if (fmt_q == FMT_PCM && bits_q == 16'd16) begin
			mode_d = SM_S16;
		end else if (fmt_q == FMT_PCM && bits_q == 16'd24) begin
			mode_d = SM_S24;
		end else if (fmt_q == FMT_PCM && bits_q == 16'd32) begin
			mode_d = SM_S32;
		end else begin
			supported = 1'b0;
		end
	end

	assign hdr_bps = bytes_per_sample(mode_d);
	assign size_d  = {din, size_lo_q};

	assign cur_bps  = bytes_per_sample(mode_q);
	assign smp_done = (3'(bis_q) + 3'd1) >= cur_bps;
	assign raw_d    = {8'd0, partial_q} | (32'(din) << {bis_q, 3'b000});
	assign rem_next = rem_q - 32'(cur_bps);
	assign smp_last = rem_next < 32'(cur_bps);

	// a status or a whole sample goes into the capture register
	assign cap_load = in_acc && (((phase_eff == PH_HEADER) && (hpos_eff == POS_LAST)) ||
		((phase_eff == PH_SAMPLES) && smp_done));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			hpos_q       <= '0;
			tag_bad_q    <= 1'b0;
			bis_q        <= '0;
			partial_q    <= '0;
			rem_q        <= '0;
			cap_valid_s1 <= 1'b0;
		end else begin
			cap_valid_s1 <= cap_load || (cap_valid_s1 && !out_load);
			if (in_acc) begin
				unique case (phase_eff)
					PH_HEADER: begin
						tag_bad_q <= tag_bad_d;
						if (hpos_eff == POS_LAST) begin
							// header complete: emit status, arm sample phase if ok and a sample is owed
							hpos_q    <= '0;
							bis_q     <= '0;
							partial_q <= '0;
							rem_q     <= size_d;
							if (!tag_bad_d && supported && size_d >= 32'(hdr_bps)) begin
								phase_q <= PH_SAMPLES;
							end else begin
								phase_q <= PH_IDLE;
							end
						end else begin
							phase_q <= PH_HEADER;
							hpos_q  <= hpos_eff + 6'd1;
						end
					end
					PH_SAMPLES: begin
						if (smp_done) begin
							bis_q     <= '0;
							partial_q <= '0;
							rem_q     <= rem_next;
							if (smp_last) begin
								phase_q <= PH_IDLE;
							end
						end else begin
							bis_q     <= bis_q + 2'd1;
							partial_q <= partial_q | (24'(din) << {bis_q, 3'b000});
						end
					end
					default: begin
						// idle: drop the byte
					end
				endcase
			end
		end
	end

	// header fields and capture payload
	always_ff @(posedge clk) begin
		if (in_acc && phase_eff == PH_HEADER) begin
			unique case (hpos_eff)
				OFS_FMT:           fmt_q[7:0]        <= din;
				OFS_FMT + 6'd1:    fmt_q[15:8]       <= din;
				OFS_CH:            ch_q[7:0]         <= din;
				OFS_CH + 6'd1:     ch_q[15:8]        <= din;
				OFS_RATE:          rate_q[7:0]       <= din;
				OFS_RATE + 6'd1:   rate_q[15:8]      <= din;
				OFS_RATE + 6'd2:   rate_q[23:16]     <= din;
				OFS_RATE + 6'd3:   rate_q[31:24]     <= din;
				OFS_BITS:          bits_q[7:0]       <= din;
				OFS_BITS + 6'd1:   bits_q[15:8]      <= din;
				OFS_SIZE:          size_lo_q[7:0]    <= din;
				OFS_SIZE + 6'd1:   size_lo_q[15:8]   <= din;
				OFS_SIZE + 6'd2:   size_lo_q[23:16]  <= din;
				default: begin
				end
			endcase
			if (hpos_eff == POS_LAST) begin
				mode_q      <= mode_d;
				cap_s1.mode <= mode_d;
				cap_s1.last <= 1'b0;
				cap_s1.raw  <= size_d;
				cap_s1.fmt  <= fmt_q;
				cap_s1.bits <= bits_q;
				cap_s1.ch   <= ch_q;
				cap_s1.rate <= rate_q;
				if (tag_bad_d) begin
					cap_s1.kind <= RK_HDR_BAD;
				end else if (!supported) begin
					cap_s1.kind <= RK_UNSUPPORTED;
				end else begin
					cap_s1.kind <= RK_HDR_OK;
				end
			end
		end
		if (in_acc && phase_eff == PH_SAMPLES && smp_done) begin
			cap_s1.kind <= RK_SAMPLE;
			cap_s1.mode <= mode_q;
			cap_s1.last <= smp_last;
			cap_s1.raw  <= raw_d;
		end
	end

	// ------------------------------------------------------------------
	// Output stage: scale to Q1.31, sample total
	// ------------------------------------------------------------------
	logic        neg;
	logic [32:0] mag;
	logic [33:0] q;
	logic [7:0]  fexp;
	logic [23:0] fman;
	logic [2:0]  flsh;
	logic [4:0]  frsh;
	logic [24:0] fhalf;
	logic [31:0] value;
	logic [63:0] prod;
	logic [31:0] total;

	assign fexp = cap_s1.raw[30:23];
	assign fman = {1'b1, cap_s1.raw[22:0]};
	assign flsh = 3'(fexp - 8'd119);
	assign frsh = 5'(8'd119 - fexp);
	assign fhalf = {fman, 1'b0} >> frsh;

	// magnitude scaled by 2^31 / (2^n - 1): shift-and-add plus a rounded tail; float aligned by its exponent
	always_comb begin
		neg = 1'b0;
		mag = '0;
		q   = '0;
		unique case (cap_s1.mode)
			SM_U8: begin
				neg = cap_s1.raw[7:0] < 8'd128;
				mag = neg ? 33'(8'd128 - cap_s1.raw[7:0]) : 33'(cap_s1.raw[7:0] - 8'd128);
				q   = (34'(mag) << 24) + (34'(mag) << 17) + (34'(mag) << 10)
					+ (34'(mag) << 3) + ((34'(mag) + 34'd8) >> 4);
			end
			SM_S16: begin
				neg = cap_s1.raw[15];
				mag = neg ? 33'(17'h1_0000 - 17'(cap_s1.raw[15:0])) : 33'(cap_s1.raw[15:0]);
				q   = (34'(mag) << 16) + (34'(mag) << 1) + ((34'(mag) + 34'h2000) >> 14);
			end
			SM_S24: begin
				neg = cap_s1.raw[23];
				mag = neg ? 33'(25'h100_0000 - 25'(cap_s1.raw[23:0])) : 33'(cap_s1.raw[23:0]);
				q   = (34'(mag) << 8) + ((34'(mag) + 34'h4000) >> 15);
			end
			SM_S32: begin
				neg = cap_s1.raw[31];
				mag = neg ? (33'h1_0000_0000 - 33'(cap_s1.raw)) : 33'(cap_s1.raw);
				q   = 34'(mag) + ((34'(mag) + 34'h4000_0000) >> 31);
			end
			SM_F32: begin
				neg = cap_s1.raw[31];
				priority if (fexp == 8'hFF) begin
					// NaN gives zero, infinity saturates
					q = (cap_s1.raw[22:0] != 23'd0) ? 34'd0 : 34'h1_0000_0000;
				end else if (fexp == 8'd0) begin
					q = '0;
				end else if (fexp >= 8'd127) begin
					q = 34'h1_0000_0000;
				end else if (fexp >= 8'd119) begin
					q = 34'(fman) << flsh;
				end else if (fexp >= 8'd94) begin
					q = 34'((26'(fhalf) + 26'd1) >> 1);
				end else begin
					q = '0;
				end
			end
			default: begin
				q = '0;
			end
		endcase
	end

	// saturate to the signed 32-bit range
	always_comb begin
		if (neg) begin
			value = (q >= 34'h8000_0000) ? 32'h8000_0000 : 32'(34'd0 - q);
		end else begin
			value = (q > 34'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		end
	end

	assign prod = {32'd0, cap_s1.raw} * {32'd0, RECIP3};

	always_comb begin
		unique case (cap_s1.mode)
			SM_U8:   total = cap_s1.raw;
			SM_S16:  total = {1'b0, cap_s1.raw[31:1]};
			SM_S24:  total = {1'b0, prod[63:33]};
			default: total = {2'b00, cap_s1.raw[31:2]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tuser <= cap_s1.kind;
			unique case (cap_s1.kind)
				RK_SAMPLE: begin
					m_axis_tlast <= cap_s1.last;
					m_axis_tdata <= {112'd0, value};
				end
				RK_HDR_OK: begin
					m_axis_tlast <= 1'b0;
					m_axis_tdata <= {total, cap_s1.rate, cap_s1.ch, cap_s1.bits,
						cap_s1.fmt, 32'd0};
				end
				default: begin
					// bad or unsupported header: status only
					m_axis_tlast <= 1'b0;
					m_axis_tdata <= '0;
				end
			endcase
		end
	end

endmodule
